@@ rtl/mt19937_random_generator_assert.svh @@
// Assertion macros for the MT19937 generator, compiled out when SYNTH is defined.
`ifndef MT19937_RANDOM_GENERATOR_ASSERT_SVH
`define MT19937_RANDOM_GENERATOR_ASSERT_SVH

`ifndef SYNTH
`define MTRG_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mtrg assertion failed");
`define MTRG_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("mtrg assertion failed");
`else
`define MTRG_ASSERT(name, clk, rst_n, prop)
`define MTRG_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

@@ rtl/mtrg_pkg.sv @@
// Types, constants and word functions shared by the MT19937 generator.
package mtrg_pkg;

  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] MATRIX_A     = 32'h9908b0df;
  localparam logic [31:0] UPPER_MASK   = 32'h80000000;
  localparam logic [31:0] LOWER_MASK   = 32'h7fffffff;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;

  localparam logic OP_NEXT = 1'b0;
  localparam logic OP_SEED = 1'b1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SEED,
    ST_DRAW
  } mtrg_state_e;

  // Control handed from the sequencer to the ring of cells
  typedef struct packed {
    logic shift;  // advance every cell by one place
    logic init;   // push the seeding word instead of the twisted word
  } ring_ctrl_t;

  function automatic logic [31:0] twist_word(input logic [31:0] w_k,
                                             input logic [31:0] w_next,
                                             input logic [31:0] w_tap);
    logic [31:0] y;
    y = (w_k & UPPER_MASK) | (w_next & LOWER_MASK);
    return w_tap ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ rtl/mtrg_cell.sv @@
// One state word of the generator ring; takes its neighbour's word on shift.
module mtrg_cell (
  input  logic        clk_i,
  input  logic        shift_i,
  input  logic [31:0] word_i,
  output logic [31:0] word_o
);

  logic [31:0] word_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      word_q <= word_i;
    end
  end

  assign word_o = word_q;

endmodule

@@ rtl/mtrg_ring.sv @@
// Chain of state cells with the twist recurrence feeding the tail.
module mtrg_ring #(
  parameter int STATE_WORDS = 624,
  parameter int TAP_OFFSET  = 397
) (
  input  logic                clk_i,
  input  mtrg_pkg::ring_ctrl_t ctrl_i,
  input  logic [31:0]         init_word_i,
  output logic [31:0]         twist_word_o,
  output logic [31:0]         tail_word_o
);
  import mtrg_pkg::*;

  logic [31:0] cell_word [STATE_WORDS];
  logic [31:0] push_word;

  // Head, its neighbour and the tap give the next word of the sequence
  assign twist_word_o = twist_word(cell_word[0], cell_word[1], cell_word[TAP_OFFSET]);
  assign push_word    = ctrl_i.init ? init_word_i : twist_word_o;
  assign tail_word_o  = cell_word[STATE_WORDS-1];

  for (genvar i = 0; i < STATE_WORDS; i++) begin : g_cell
    logic [31:0] cell_in;
    if (i == STATE_WORDS - 1) begin : g_tail
      assign cell_in = push_word;
    end else begin : g_body
      assign cell_in = cell_word[i+1];
    end
    mtrg_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctrl_i.shift),
      .word_i  (cell_in),
      .word_o  (cell_word[i])
    );
  end

endmodule

@@ rtl/mt19937_random_generator.sv @@
// MT19937 generator top: sequencer, output register and ring of state cells.
// Next transaction: word appears in the cycle after acceptance; one word per cycle sustained while the output is taken.
// Each word is one shift of the 624-cell ring, so the table twists word by word.
// Seed transaction: ring is refilled one cell per cycle; input stalls meanwhile.
// First next transaction after reset seeds with 5489 first, then draws the word.
// Reset clears control and output valid; the state words hold nothing until seeded.
`include "mt19937_random_generator_assert.svh"

module mt19937_random_generator #(
  parameter int STATE_WORDS = 624,
  parameter int TAP_OFFSET  = 397
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] seed_value
  input  logic        s_axis_tuser_i,   // [0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] random_word
);
  import mtrg_pkg::*;

  localparam int CntW = $clog2(STATE_WORDS);
  localparam logic [CntW-1:0] LastCnt = CntW'(STATE_WORDS - 1);

  mtrg_state_e   state_q, state_d;
  logic [CntW-1:0] seed_cnt_q, seed_cnt_d;
  logic          seeded_q, seeded_d;
  logic          pending_q, pending_d;
  logic [31:0]   seed_val_q, seed_val_d;
  logic          out_valid_q, out_valid_d;
  logic [31:0]   out_word_q, out_word_d;

  ring_ctrl_t    ring_ctrl;
  logic [31:0]   init_word;
  logic [31:0]   twist_word_w;
  logic [31:0]   tail_word;
  logic [31:0]   init_mix;
  logic [31:0]   init_prod;
  logic          in_fire;
  logic          slot_free;
  logic          gen;

  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;

  // Seeding recurrence on the word pushed last cycle
  assign init_mix  = tail_word ^ (tail_word >> 30);
  assign init_prod = INIT_MULT * init_mix;
  assign init_word = (seed_cnt_q == '0) ? seed_val_q
                                        : init_prod + {{(32-CntW){1'b0}}, seed_cnt_q};

  mtrg_ring #(
    .STATE_WORDS (STATE_WORDS),
    .TAP_OFFSET  (TAP_OFFSET)
  ) u_ring (
    .clk_i        (clk_i),
    .ctrl_i       (ring_ctrl),
    .init_word_i  (init_word),
    .twist_word_o (twist_word_w),
    .tail_word_o  (tail_word)
  );

  // Next state
  always_comb begin
    state_d    = state_q;
    seed_cnt_d = seed_cnt_q;
    seeded_d   = seeded_q;
    pending_d  = pending_q;
    seed_val_d = seed_val_q;
    case (state_q)
      ST_RUN: begin
        if (in_fire) begin
          if (s_axis_tuser_i == OP_SEED) begin
            state_d    = ST_SEED;
            seed_cnt_d = '0;
            seed_val_d = s_axis_tdata_i;
            pending_d  = 1'b0;
          end else if (!seeded_q) begin
            state_d    = ST_SEED;
            seed_cnt_d = '0;
            seed_val_d = DEFAULT_SEED;
            pending_d  = 1'b1;
          end
        end
      end
      ST_SEED: begin
        seed_cnt_d = seed_cnt_q + 1'b1;
        if (seed_cnt_q == LastCnt) begin
          seeded_d = 1'b1;
          state_d  = pending_q ? ST_DRAW : ST_RUN;
        end
      end
      ST_DRAW: begin
        if (slot_free) begin
          state_d   = ST_RUN;
          pending_d = 1'b0;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready_o = 1'b0;
    gen             = 1'b0;
    ring_ctrl       = '0;
    case (state_q)
      ST_RUN: begin
        s_axis_tready_o = slot_free;
        gen = in_fire && (s_axis_tuser_i == OP_NEXT) && seeded_q;
        ring_ctrl.shift = gen;
      end
      ST_SEED: begin
        ring_ctrl.shift = 1'b1;
        ring_ctrl.init  = 1'b1;
      end
      ST_DRAW: begin
        gen             = slot_free;
        ring_ctrl.shift = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (gen) begin
      out_valid_d = 1'b1;
      out_word_d  = temper(twist_word_w);
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      seed_cnt_q  <= '0;
      seeded_q    <= 1'b0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_cnt_q  <= seed_cnt_d;
      seeded_q    <= seeded_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_val_q <= seed_val_d;
    out_word_q <= out_word_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_word_q;

  `MTRG_ASSERT(a_seed_stalls_input, clk_i, rst_ni, (state_q == ST_SEED) |-> !s_axis_tready_o)
  `MTRG_ASSERT(a_no_overwrite, clk_i, rst_ni, (out_valid_q && !m_axis_tready_i) |-> !gen)
  `MTRG_ASSERT(a_seed_done, clk_i, rst_ni, (state_q == ST_SEED && seed_cnt_q == LastCnt) |=> seeded_q)
  `MTRG_ASSERT_ALWAYS(a_gen_needs_seed, clk_i, gen |-> seeded_q)

endmodule
